// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define ASSERT_CLKD_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lzss_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the LZSS decoder.
`timescale 1ns / 1ps

package lzss_pkg;

    // Window geometry
    localparam int WINDOW_SIZE = 4096;
    localparam int LOOKAHEAD   = 16;
    localparam int PTR_W       = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = PTR_W + 1;

    // Byte and counter widths
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 24;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 5;
    localparam int MIN_MATCH   = 3;

    localparam logic [PTR_W-1:0] WPOS_RESET     = PTR_W'(WINDOW_SIZE - LOOKAHEAD);
    localparam logic [CNT_W-1:0] MAX_SIZE_RESET = CNT_W'(65536);

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_LIMIT = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    // What the next input beat is expected to be
    typedef enum logic [1:0] {
        KIND_FLAG,
        KIND_ITEM,
        KIND_TOKEN_HIGH
    } expect_t;

    // Decoded meaning of the beat at the input
    typedef enum logic [1:0] {
        BEAT_FLAG,
        BEAT_LITERAL,
        BEAT_TOKEN_LOW,
        BEAT_TOKEN_HIGH
    } beat_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic emit_lit;
        logic emit_err;
        logic copy_read;
        logic copy_emit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        beat_kind_t kind;
        logic       skip;
        logic       out_free;
        logic       copy_stop;
    } dp_status_t;

endpackage

// ----- rtl/lzss_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read; read data holds when re is low
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lzss_datapath.sv -----
// Datapath: window RAM, decode state, copy pointers, byte counter and output register.
`timescale 1ns / 1ps

module lzss_datapath import lzss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    input  logic [CNT_W-1:0]  max_size,
    input  dp_cmd_t           cmd,
    output dp_status_t        sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [STATUS_W-1:0] m_tuser
);

    localparam logic [3:0]        FLAG_DONE = 4'd8;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SIZE);

    // Control state
    expect_t            expect_reg,    expect_next;
    logic [BYTE_W-1:0]  flag_bits_reg, flag_bits_next;
    logic [3:0]         flag_idx_reg,  flag_idx_next;
    logic [PTR_W-1:0]   wpos_reg,      wpos_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic [CNT_W-1:0]   produced_reg,  produced_next;
    logic               finished_reg,  finished_next;
    logic               m_valid_reg,   m_valid_next;

    // Payload
    logic [BYTE_W-1:0]  token_low_reg, token_low_next;
    logic [BYTE_W-1:0]  lit_reg,       lit_next;
    logic [PTR_W-1:0]   src_reg,       src_next;
    logic [LEN_W-1:0]   left_reg,      left_next;
    logic               src_ok_reg,    src_ok_next;
    logic [BYTE_W-1:0]  m_data_reg,    m_data_next;
    logic               m_last_reg,    m_last_next;
    status_t            m_status_reg,  m_status_next;

    beat_kind_t         kind;
    logic               limit_met;
    logic               reach;
    logic               copy_last;
    logic               out_free;
    logic               take;
    logic [3:0]         flag_idx_inc;
    logic [PTR_W-1:0]   src_off;
    logic [PTR_W-1:0]   back_dist;
    logic [BYTE_W-1:0]  rd_data;
    logic [BYTE_W-1:0]  copy_byte;
    logic               ram_we;
    logic [BYTE_W-1:0]  ram_wdata;

    // Decode of the beat at the input
    always_comb begin
        case (expect_reg)
            KIND_FLAG:       kind = BEAT_FLAG;
            KIND_ITEM:       kind = flag_bits_reg[flag_idx_reg[2:0]] ? BEAT_TOKEN_LOW
                                                                     : BEAT_LITERAL;
            KIND_TOKEN_HIGH: kind = BEAT_TOKEN_HIGH;
            default:         kind = BEAT_FLAG;
        endcase
    end

    assign limit_met    = produced_reg >= max_size;
    assign reach        = (produced_reg + CNT_W'(1)) >= max_size;
    assign copy_last    = left_reg == LEN_W'(1);
    assign out_free     = !m_valid_reg || m_tready;
    assign take         = cmd.accept && !finished_reg && !limit_met;
    assign flag_idx_inc = flag_idx_reg + 4'd1;
    assign src_off      = src_reg - WPOS_RESET;
    assign back_dist    = PTR_W'({in_byte[3:0], token_low_reg});
    assign copy_byte    = src_ok_reg ? rd_data : '0;

    assign sts.kind      = kind;
    assign sts.skip      = finished_reg || limit_met;
    assign sts.out_free  = out_free;
    assign sts.copy_stop = copy_last || reach;

    // Window writes: literals on accept, copied bytes on emit
    assign ram_we    = (take && kind == BEAT_LITERAL) || cmd.copy_emit;
    assign ram_wdata = cmd.copy_emit ? copy_byte : in_byte;

    lzss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (ram_wdata),
        .re    (cmd.copy_read),
        .raddr (src_reg),
        .rdata (rd_data)
    );

    // Next-state logic
    always_comb begin
        expect_next    = expect_reg;
        flag_bits_next = flag_bits_reg;
        flag_idx_next  = flag_idx_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        produced_next  = produced_reg;
        finished_next  = finished_reg;
        token_low_next = token_low_reg;
        lit_next       = lit_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        src_ok_next    = src_ok_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;

        // Input beat
        if (cmd.accept) begin
            if (sts.skip || in_end) begin
                finished_next = 1'b1;
            end
            if (take) begin
                case (kind)
                    BEAT_FLAG: begin
                        flag_bits_next = in_byte;
                        flag_idx_next  = 4'd0;
                        expect_next    = KIND_ITEM;
                    end
                    BEAT_LITERAL: begin
                        lit_next  = in_byte;
                        wpos_next = wpos_reg + PTR_W'(1);
                        if (fill_reg != FILL_FULL) begin
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    BEAT_TOKEN_LOW: begin
                        token_low_next = in_byte;
                        expect_next    = KIND_TOKEN_HIGH;
                    end
                    BEAT_TOKEN_HIGH: begin
                        left_next = {1'b0, in_byte[7:4]} + LEN_W'(MIN_MATCH);
                        src_next  = wpos_reg - back_dist - PTR_W'(1);
                    end
                    default: begin
                    end
                endcase
                // Step the flag bit after a literal or a whole token
                if (kind == BEAT_LITERAL || kind == BEAT_TOKEN_HIGH) begin
                    if (flag_idx_inc >= FLAG_DONE) begin
                        flag_idx_next = FLAG_DONE;
                        expect_next   = KIND_FLAG;
                    end else begin
                        flag_idx_next = flag_idx_inc;
                        expect_next   = KIND_ITEM;
                    end
                end
            end
        end

        // Copy read: note whether the source entry was ever written
        if (cmd.copy_read) begin
            src_ok_next = {1'b0, src_off} < fill_reg;
        end

        // Copy emit: write back, advance pointers
        if (cmd.copy_emit) begin
            wpos_next = wpos_reg + PTR_W'(1);
            src_next  = src_reg + PTR_W'(1);
            left_next = left_reg - LEN_W'(1);
            if (fill_reg != FILL_FULL) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        // Output register loads
        if (cmd.emit_lit || cmd.copy_emit) begin
            m_valid_next  = 1'b1;
            m_data_next   = cmd.copy_emit ? copy_byte : lit_reg;
            m_last_next   = cmd.emit_lit || copy_last || reach;
            m_status_next = reach ? STATUS_LIMIT : STATUS_DATA;
            produced_next = produced_reg + CNT_W'(1);
            if (reach) begin
                finished_next = 1'b1;
            end
        end
        if (cmd.emit_err) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_last_next   = 1'b1;
            m_status_next = STATUS_ERROR;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg    <= KIND_FLAG;
            flag_bits_reg <= '0;
            flag_idx_reg  <= FLAG_DONE;
            wpos_reg      <= WPOS_RESET;
            fill_reg      <= '0;
            produced_reg  <= '0;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            expect_reg    <= expect_next;
            flag_bits_reg <= flag_bits_next;
            flag_idx_reg  <= flag_idx_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            produced_reg  <= produced_next;
            finished_reg  <= finished_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        token_low_reg <= token_low_next;
        lit_reg       <= lit_next;
        src_reg       <= src_next;
        left_reg      <= left_next;
        src_ok_reg    <= src_ok_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ----- rtl/lzss_ctrl.sv -----
// Controller: sequences input acceptance, literal/error emission and the token copy loop.
`timescale 1ns / 1ps

module lzss_ctrl import lzss_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tlast,
    output logic       s_tready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_ERR,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid && ready_reg;
                if (cmd.accept && !sts.skip) begin
                    case (sts.kind)
                        BEAT_LITERAL:    state_next = ST_LIT;
                        BEAT_TOKEN_LOW:  state_next = s_tlast ? ST_ERR : ST_IDLE;
                        BEAT_TOKEN_HIGH: state_next = ST_COPY_RD;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LIT: begin
                if (sts.out_free) begin
                    cmd.emit_lit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_COPY_RD: begin
                cmd.copy_read = 1'b1;
                state_next    = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (sts.out_free) begin
                    cmd.copy_emit = 1'b1;
                    state_next    = sts.copy_stop ? ST_IDLE : ST_COPY_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = state_next == ST_IDLE;
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ----- rtl/lzss_window_decompressor.sv -----
// Top level of the LZSS decoder with a 4096-byte window and an APB limit register.
//
// Input stream: one compressed byte per beat on s_tdata; s_tlast marks the last
// byte of the stream. Output stream: one decoded byte per beat on m_tdata;
// m_tlast marks the last byte caused by one input beat; m_tuser carries status
// (data, data reaching max_size, truncated token error).
// APB register 0 (address 0) is max_size, 24 bits, reset 65536. Write it only idle.
// Per input beat: flag and token low bytes are taken in idle; a literal goes through
// the literal emit state; a token high byte starts a copy of 3 to 18 bytes, each read
// and then written on the single window RAM, which sets the copy rate. A result
// shows on the output in the cycle after its emit cycle.
// Reset: s_tready is high right after reset; a fill count makes unwritten window
// entries read as zero, so there is no clearing pass.
// Stall: a result waits in the output register; a flag or token-low beat is still
// taken behind it, and the controller holds in its emit state until m_tready.
// After the stream ends, an error or the limit, beats are taken and dropped until reset.
`timescale 1ns / 1ps

module lzss_window_decompressor import lzss_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Compressed input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                s_tlast,   // stream_end
    // Decoded output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tlast,   // run_last
    output logic [1:0]          m_tuser,   // [1:0] status
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_MAX_SIZE = 1'b0;

    logic [CNT_W-1:0] max_size_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       sts;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= MAX_SIZE_RESET;
        end else if (cfg_write && paddr[2] == REG_MAX_SIZE) begin
            max_size_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_SIZE) ? {{(32 - CNT_W){1'b0}}, max_size_reg}
                                                : '0;

    lzss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzss_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .max_size (max_size_reg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/lzss_checker.sv -----
// Port-level checker for the LZSS decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzss_checker import lzss_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // A stalled result beat holds its payload
    `ASSERT_CLKD(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast),
        "output beat changed while stalled")

    // Truncated token error is a single zero byte closing the run
    `ASSERT_CLKD(a_err_beat, aclk, aresetn,
        m_tvalid && m_tuser == STATUS_ERROR |-> m_tdata == 8'd0 && m_tlast,
        "error beat not zero or not last")

    // The byte reaching the limit closes the run
    `ASSERT_CLKD(a_limit_last, aclk, aresetn,
        m_tvalid && m_tuser == STATUS_LIMIT |-> m_tlast,
        "limit beat not last")

    // Reset empties the output register
    `ASSERT_CLKD_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_tvalid,
        "output valid after reset")

endmodule

bind lzss_window_decompressor lzss_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ----- sim/lzss_window_decompressor_test.sv -----
// Self-checking testbench for the LZSS window decompressor: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module lzss_window_decompressor_test;
    import lzss_pkg::*;

    localparam logic [2:0] MAX_SIZE_ADDR = 3'd0;
    localparam int MAX_WAIT      = 18;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 56;

    // Directed content: eight literals, then eight tokens as {high, low} pairs
    localparam logic [63:0]  DIR_LITERALS = 64'h00FF0180_55AA7FFE;
    localparam logic [127:0] DIR_TOKENS   =
        128'h0000_F000_FFFF_0FFF_F001_800F_3A10_5CC3;

    // How the compressed stream is brought to its end
    typedef enum {END_LIMIT_HIT, END_LIMIT_MET, END_TRUNCATED, END_CLEAN} finish_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } comp_beat_t;

    typedef struct packed {
        status_t    status;
        logic       last;
        logic [7:0] data;
    } dec_byte_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;    // stream_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;            // run_last
    logic [1:0]  m_tuser;            // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = MAX_SIZE_ADDR;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and checking bookkeeping
    comp_beat_t comp_q[$];
    dec_byte_t  decoded_q[$];
    int  mismatches = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    bit  in_fire    = 1'b0;
    bit  out_fire   = 1'b0;
    bit  src_steady = 1'b0;
    bit  sink_steady = 1'b0;

    // Predictor state
    logic [7:0]  hist_win [WINDOW_SIZE];
    logic [11:0] wr_ptr    = WPOS_RESET;
    logic [7:0]  flag_byte = 8'h00;
    logic [3:0]  flag_pos  = 4'd8;
    expect_t     want      = KIND_FLAG;
    logic [7:0]  low_byte  = 8'h00;
    logic [23:0] out_count = 24'd0;
    logic [23:0] lim_size  = MAX_SIZE_RESET;
    bit          dec_done  = 1'b0;
    dec_byte_t   held;
    bit          have_held = 1'b0;

    lzss_window_decompressor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic int draw_wait(input bit steady);
        if (steady || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // One decoded byte is held back so the last of a beat can be marked
    function automatic void stage_result(input logic [7:0] b, input status_t st);
        if (have_held) begin
            decoded_q.push_back(held);
        end
        held.data   = b;
        held.last   = 1'b0;
        held.status = st;
        have_held   = 1'b1;
    endfunction

    function automatic void flush_step();
        if (have_held) begin
            held.last = 1'b1;
            decoded_q.push_back(held);
            have_held = 1'b0;
        end
    endfunction

    // Emits one data byte under the size limit; 0 once decoding has to stop
    function automatic bit emit_data(input logic [7:0] b);
        if (out_count >= lim_size) begin
            dec_done = 1'b1;
            return 1'b0;
        end
        out_count = out_count + 24'd1;
        stage_result(b, (out_count >= lim_size) ? STATUS_LIMIT : STATUS_DATA);
        if (out_count >= lim_size) begin
            dec_done = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void step_flag();
        flag_pos = flag_pos + 4'd1;
        if (flag_pos >= 4'd8) begin
            flag_pos = 4'd8;
            want     = KIND_FLAG;
        end else begin
            want = KIND_ITEM;
        end
    endfunction

    // Works out the decoded bytes caused by one compressed beat
    task automatic decode_beat(input logic [7:0] b, input logic last);
        logic [11:0] src;
        logic [7:0]  v;
        int          len;
        int          n;
        bit          going;
        if (!dec_done) begin
            if (out_count >= lim_size) begin
                dec_done = 1'b1;
            end else begin
                case (want)
                    KIND_FLAG: begin
                        flag_byte = b;
                        flag_pos  = 4'd0;
                        want      = KIND_ITEM;
                    end
                    KIND_ITEM: begin
                        if (flag_byte[flag_pos[2:0]]) begin
                            low_byte = b;
                            want     = KIND_TOKEN_HIGH;
                            // stream cut between the two token bytes
                            if (last) begin
                                stage_result(8'h00, STATUS_ERROR);
                            end
                        end else begin
                            hist_win[wr_ptr] = b;
                            wr_ptr = wr_ptr + 12'd1;
                            void'(emit_data(b));
                            step_flag();
                        end
                    end
                    default: begin
                        len   = int'(b[7:4]) + MIN_MATCH;
                        src   = wr_ptr - {b[3:0], low_byte} - 12'd1;
                        going = 1'b1;
                        n     = 0;
                        // byte-by-byte copy, so overlapping sources repeat
                        while (going && n < len) begin
                            v = hist_win[src];
                            hist_win[wr_ptr] = v;
                            src    = src + 12'd1;
                            wr_ptr = wr_ptr + 12'd1;
                            going  = emit_data(v);
                            n++;
                        end
                        step_flag();
                    end
                endcase
                if (last) begin
                    dec_done = 1'b1;
                end
                flush_step();
            end
        end
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic last);
        comp_beat_t cb;
        cb.data = b;
        cb.last = last;
        comp_q.push_back(cb);
    endtask

    // Flag byte plus the eight literals and tokens it announces
    task automatic queue_group(output int beats);
        logic [7:0]  flags;
        logic [11:0] offset;
        int          k;
        case ($urandom_range(0, 3))
            0: flags = 8'h00;
            1: flags = 8'hFF;
            default: flags = 8'($urandom);
        endcase
        queue_beat(flags, 1'b0);
        beats = 1;
        for (k = 0; k < 8; k++) begin
            if (flags[k]) begin
                // short distances often, to get overlapping copies
                if ($urandom_range(0, 1) == 0) begin
                    offset = 12'($urandom_range(0, 15));
                end else begin
                    offset = 12'($urandom);
                end
                queue_beat(offset[7:0], 1'b0);
                queue_beat({4'($urandom), offset[11:8]}, 1'b0);
                beats += 2;
            end else begin
                queue_beat(8'($urandom), 1'b0);
                beats += 1;
            end
        end
    endtask

    task automatic write_limit(input logic [23:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MAX_SIZE_ADDR;
        pwdata  <= {8'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        lim_size = val;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_limit();
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= MAX_SIZE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {8'h00, lim_size}) begin
            report($sformatf("max_size read %h exp %h", prdata, lim_size));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Holds off until every beat is taken and every decoded byte has come out
    task automatic wait_drained();
        while (comp_q.size() != 0 || s_tvalid || decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Compressed beat driver
    always @(negedge aclk) begin
        comp_beat_t nb;
        if (aresetn && (!s_tvalid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (comp_q.size() != 0) begin
                nb = comp_q.pop_front();
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
                s_tvalid <= 1'b1;
                gap_left = draw_wait(src_steady);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Decoded byte receiver stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                stall_left = draw_wait(sink_steady);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on input beats, checks output beats in order
    always @(posedge aclk) begin
        dec_byte_t exp_b;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            decode_beat(s_tdata, s_tlast);
        end
        if (out_fire) begin
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected beat data %h last %b user %0d",
                                 m_tdata, m_tlast, m_tuser));
            end else begin
                exp_b = decoded_q.pop_front();
                if (m_tdata !== exp_b.data) begin
                    report($sformatf("out_byte %h exp %h", m_tdata, exp_b.data));
                end
                if (m_tlast !== exp_b.last) begin
                    report($sformatf("run_last %b exp %b", m_tlast, exp_b.last));
                end
                if (m_tuser !== exp_b.status) begin
                    report($sformatf("status code %0d exp %0d", m_tuser, exp_b.status));
                end
            end
        end
    end

    // Main sequence
    initial begin
        finish_t ending;
        int      i;
        int      k;
        int      phase;
        int      queued;
        int      beats;
        int      stop_at;
        for (i = 0; i < WINDOW_SIZE; i++) begin
            hist_win[i] = 8'h00;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        read_limit();
        write_limit(24'hFFFFFF);
        read_limit();

        // Directed: extreme literals, then tokens at the distance and length extremes
        src_steady  = 1'b1;
        sink_steady = 1'b0;
        queue_beat(8'h00, 1'b0);
        for (k = 7; k >= 0; k--) begin
            queue_beat(DIR_LITERALS[8*k +: 8], 1'b0);
        end
        queue_beat(8'hFF, 1'b0);
        for (k = 7; k >= 0; k--) begin
            queue_beat(DIR_TOKENS[16*k +: 8], 1'b0);
            queue_beat(DIR_TOKENS[16*k+8 +: 8], 1'b0);
        end
        wait_drained();

        // Random well-formed groups under changing limits and idling
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            src_steady  = (phase == 1) || ($urandom_range(0, 3) == 0);
            sink_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                write_limit(MAX_SIZE_RESET);
            end else if (phase == 2) begin
                write_limit(24'hFFFFFF);
            end else begin
                write_limit(24'($urandom_range(int'(out_count) + 1000, 24'hFFFFFF)));
            end
            queued = 0;
            while (queued < PHASE_BEATS) begin
                queue_group(beats);
                queued += beats;
            end
            wait_drained();
        end

        // Bring the stream to an end one of four ways
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        ending = finish_t'($urandom_range(0, 3));
        case (ending)
            END_LIMIT_HIT: begin
                // limit falls inside a long copy
                write_limit(out_count + 24'($urandom_range(1, 10)));
                queue_beat(8'hFF, 1'b0);
                for (k = 0; k < 3; k++) begin
                    queue_beat(8'($urandom), 1'b0);
                    queue_beat({4'hF, 4'($urandom)}, 1'b0);
                end
            end
            END_LIMIT_MET: begin
                write_limit(24'($urandom_range(0, int'(out_count))));
                queue_beat(8'h00, 1'b0);
                queue_beat(8'($urandom), 1'b0);
            end
            END_TRUNCATED: begin
                queue_beat(8'($urandom) | 8'h01, 1'b0);
                queue_beat(8'($urandom), 1'b1);
            end
            default: begin
                // flag announces a literal then a token; stop on flag, literal or token high
                stop_at = $urandom_range(0, 2);
                queue_beat(8'h02, stop_at == 0);
                if (stop_at != 0) begin
                    queue_beat(8'($urandom), stop_at == 1);
                end
                if (stop_at == 2) begin
                    queue_beat(8'($urandom), 1'b0);
                    queue_beat(8'($urandom), 1'b1);
                end
            end
        endcase
        // decoder is finished: these are dropped
        queue_beat(8'($urandom), 1'b0);
        queue_beat(8'($urandom), 1'b1);
        queue_beat(8'($urandom), 1'b0);
        wait_drained();

        write_limit(24'd0);
        read_limit();
        queue_beat(8'h00, 1'b1);
        queue_beat(8'hFF, 1'b0);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
